/* hdl/ipye_pkg.sv */
// shared types, constants and the arctangent table for the pitch and yaw estimator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package ipye_pkg;
    localparam int CORDIC_STEPS = 16;
    localparam int TABLE_LEN    = 24;
    localparam int NSTEPS       = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

    localparam logic signed [19:0] HALF_PI_Q16 = 20'sd102944;
    localparam logic signed [19:0] PI_Q16      = 20'sd205887;
    localparam logic signed [20:0] RATE_K      = 21'sd571918;

    localparam logic [1:0] REG_BLEND   = 2'd0;
    localparam logic [1:0] REG_PERIOD  = 2'd1;
    localparam logic [1:0] REG_ROTATED = 2'd2;

    localparam logic [15:0] BLEND_RESET  = 16'd64225;
    localparam logic [15:0] PERIOD_RESET = 16'd655;

    typedef struct packed {
        logic signed [16:0] ay;
        logic signed [16:0] az;
        logic signed [15:0] wp;
        logic signed [15:0] wy;
    } t_item;

    typedef struct packed {
        logic [15:0] tau;
        logic [15:0] period;
    } t_cfg;

    function automatic logic signed [19:0] atan_tab(input logic [4:0] idx);
        logic signed [19:0] v;
        case (idx)
            5'd0:    v = 20'sd51472;
            5'd1:    v = 20'sd30386;
            5'd2:    v = 20'sd16055;
            5'd3:    v = 20'sd8150;
            5'd4:    v = 20'sd4091;
            5'd5:    v = 20'sd2047;
            5'd6:    v = 20'sd1024;
            5'd7:    v = 20'sd512;
            5'd8:    v = 20'sd256;
            5'd9:    v = 20'sd128;
            5'd10:   v = 20'sd64;
            5'd11:   v = 20'sd32;
            5'd12:   v = 20'sd16;
            5'd13:   v = 20'sd8;
            5'd14:   v = 20'sd4;
            5'd15:   v = 20'sd2;
            5'd16:   v = 20'sd1;
            default: v = 20'sd0;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

/* hdl/ipye_front.sv */
// front end: configuration registers, axis mapping and a two-entry request queue
// depends on ipye_pkg
`timescale 1ns / 1ps
`default_nettype none
module ipye_front import ipye_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic signed [15:0] i_accel_y_raw,
    input  wire logic signed [15:0] i_accel_z_raw,
    input  wire logic signed [15:0] i_gyro_x_raw,
    input  wire logic signed [15:0] i_gyro_y_raw,
    input  wire logic signed [15:0] i_gyro_z_raw,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [15:0]        i_cfg_data,
    output t_cfg                    o_cfg,
    output logic                    o_q_valid,
    input  wire logic               i_q_ready,
    output t_item                   o_q_item
);
    logic [15:0] r_tau, r_period;
    logic        r_rot;
    t_item       r_mem [2];
    logic        r_wr, r_rd;
    logic [1:0]  r_cnt;
    t_item       n_item;
    logic        push, pop;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = '{tau: r_tau, period: r_period};
    assign o_in_ready  = (r_cnt != 2'd2);
    assign o_q_valid   = (r_cnt != 2'd0);
    assign o_q_item    = r_mem[r_rd];
    assign push        = i_in_valid && o_in_ready;
    assign pop         = o_q_valid && i_q_ready;

    always_comb begin
        n_item.wp = i_gyro_x_raw;
        if (r_rot) begin
            n_item.ay = -{i_accel_z_raw[15], i_accel_z_raw};
            n_item.az = {i_accel_y_raw[15], i_accel_y_raw};
            n_item.wy = i_gyro_y_raw;
        end else begin
            n_item.ay = {i_accel_y_raw[15], i_accel_y_raw};
            n_item.az = {i_accel_z_raw[15], i_accel_z_raw};
            n_item.wy = i_gyro_z_raw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tau    <= BLEND_RESET;
            r_period <= PERIOD_RESET;
            r_rot    <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_BLEND:   r_tau    <= i_cfg_data;
                REG_PERIOD:  r_period <= i_cfg_data;
                REG_ROTATED: r_rot    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wr] <= n_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wr <= ~r_wr;
            if (pop)  r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

/* hdl/ipye_back.sv */
// back end: cordic arctangent, rate scaling, blend and yaw integration, result register
// depends on ipye_pkg
`timescale 1ns / 1ps
`default_nettype none
module ipye_back import ipye_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  t_cfg                    i_cfg,
    input  wire logic               i_q_valid,
    output logic                    o_q_ready,
    input  t_item                   i_q_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic signed [18:0]      o_pitch_angle,
    output logic signed [31:0]      o_yaw_angle
);
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CORD  = 3'd1;
    localparam logic [2:0] ST_MUL1  = 3'd2;
    localparam logic [2:0] ST_MUL2  = 3'd3;
    localparam logic [2:0] ST_RND   = 3'd4;
    localparam logic [2:0] ST_BLEND = 3'd5;
    localparam logic [2:0] ST_FIN   = 3'd6;
    localparam logic [4:0] LAST     = 5'(NSTEPS - 1);

    logic [2:0]                r_state;
    logic [4:0]                r_cnt;
    logic signed [33:0]        r_x, r_y;
    logic signed [19:0]        r_z;
    logic                      r_zero;
    logic signed [15:0]        r_wp, r_wy;
    logic signed [18:0]        r_acc;
    logic signed [32:0]        r_p1p, r_p1y;
    logic signed [53:0]        r_p2p, r_p2y;
    logic signed [21:0]        r_dp, r_dy;
    logic signed [39:0]        r_m1;
    logic signed [36:0]        r_m2;
    logic signed [31:0]        r_yaw_n;
    logic signed [18:0]        r_pitch;
    logic signed [31:0]        r_yaw;
    logic                      r_out_valid;
    logic signed [18:0]        r_out_p;
    logic signed [31:0]        r_out_y;

    logic signed [16:0]        px, py;
    logic signed [19:0]        pz;
    logic signed [33:0]        dx, dy;
    logic signed [19:0]        tab;
    logic signed [21:0]        dp_c, dy_c;
    logic signed [40:0]        sum;
    logic [40:0]               smag;
    logic [24:0]               srnd;
    logic signed [25:0]        np_w;
    logic signed [18:0]        np;
    logic signed [32:0]        ysum;
    logic signed [31:0]        ny;
    logic signed [22:0]        diff;
    logic                      out_free;

    function automatic logic signed [21:0] rnd32(input logic signed [53:0] v);
        logic [53:0] mag;
        logic [53:0] t;
        logic signed [21:0] r;
        mag = v[53] ? 54'(-v) : 54'(v);
        t   = mag + 54'(64'h8000_0000);
        r   = signed'({1'b0, t[52:32]});
        return v[53] ? -r : r;
    endfunction

    always_comb begin
        px = i_q_item.az;
        py = i_q_item.ay;
        pz = '0;
        if (i_q_item.az[16]) begin
            if (!i_q_item.ay[16]) begin
                px = i_q_item.ay;
                py = -i_q_item.az;
                pz = HALF_PI_Q16;
            end else begin
                px = -i_q_item.ay;
                py = i_q_item.az;
                pz = -HALF_PI_Q16;
            end
        end
    end

    assign dx  = r_y >>> r_cnt;
    assign dy  = r_x >>> r_cnt;
    assign tab = atan_tab(r_cnt);

    assign dp_c = rnd32(r_p2p);
    assign dy_c = rnd32(r_p2y);
    assign diff = 23'(r_pitch) - 23'(r_dp);

    always_comb begin
        sum  = 41'(r_m1) - 41'(r_m2);
        smag = sum[40] ? 41'(-sum) : 41'(sum);
        srnd = 25'((smag + 41'd32768) >> 16);
        np_w = sum[40] ? -signed'({1'b0, srnd}) : signed'({1'b0, srnd});
        if (np_w > 26'(PI_Q16))       np = 19'(PI_Q16);
        else if (np_w < -26'(PI_Q16)) np = 19'(-PI_Q16);
        else                          np = 19'(np_w);
        ysum = 33'(r_yaw) + 33'(r_dy);
        if (ysum > 33'sh0_7FFF_FFFF)       ny = 32'sh7FFF_FFFF;
        else if (ysum < -33'sh0_8000_0000) ny = 32'sh8000_0000;
        else                               ny = 32'(ysum);
    end

    assign out_free      = !r_out_valid || i_out_ready;
    assign o_q_ready     = (r_state == ST_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_pitch_angle = r_out_p;
    assign o_yaw_angle   = r_out_y;

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_x    <= 34'(px) <<< 14;
                r_y    <= 34'(py) <<< 14;
                r_z    <= pz;
                r_zero <= (i_q_item.ay == '0) && (i_q_item.az == '0);
                r_wp   <= i_q_item.wp;
                r_wy   <= i_q_item.wy;
                r_cnt  <= '0;
            end
            ST_CORD: begin
                r_cnt <= r_cnt + 5'd1;
                if (r_y > 0) begin
                    r_x <= r_x + dx;
                    r_y <= r_y - dy;
                    r_z <= r_z + tab;
                end else begin
                    r_x <= r_x - dx;
                    r_y <= r_y + dy;
                    r_z <= r_z - tab;
                end
            end
            ST_MUL1: begin
                r_p1p <= r_wp * signed'({1'b0, i_cfg.period});
                r_p1y <= r_wy * signed'({1'b0, i_cfg.period});
                if (r_zero)               r_acc <= '0;
                else if (r_z > PI_Q16)    r_acc <= 19'(PI_Q16);
                else if (r_z < -PI_Q16)   r_acc <= 19'(-PI_Q16);
                else                      r_acc <= 19'(r_z);
            end
            ST_MUL2: begin
                r_p2p <= 54'(r_p1p) * 54'(RATE_K);
                r_p2y <= 54'(r_p1y) * 54'(RATE_K);
            end
            ST_RND: begin
                r_dp <= dp_c;
                r_dy <= dy_c;
            end
            ST_BLEND: begin
                r_m1 <= 40'(signed'({1'b0, i_cfg.tau})) * 40'(diff);
                r_m2 <= 37'(signed'(18'sd65536 - signed'({2'b0, i_cfg.tau}))) * 37'(r_acc);
            end
            default: ;
        endcase
        if (r_state == ST_FIN && out_free) begin
            r_out_p <= np;
            r_out_y <= ny;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pitch     <= '0;
            r_yaw       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == ST_FIN && out_free) r_out_valid <= 1'b1;
            else if (i_out_ready)              r_out_valid <= 1'b0;
            case (r_state)
                ST_IDLE:  if (i_q_valid) r_state <= ST_CORD;
                ST_CORD:  if (r_cnt == LAST) r_state <= ST_MUL1;
                ST_MUL1:  r_state <= ST_MUL2;
                ST_MUL2:  r_state <= ST_RND;
                ST_RND:   r_state <= ST_BLEND;
                ST_BLEND: r_state <= ST_FIN;
                ST_FIN: begin
                    if (out_free) begin
                        r_pitch     <= np;
                        r_yaw       <= ny;
                        r_state     <= ST_IDLE;
                    end
                end
                default:  r_state <= ST_IDLE;
            endcase
        end
    end

    a_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pitch <= 19'(PI_Q16)) && (r_pitch >= 19'(-PI_Q16)))
        else $error("kept pitch out of range");
    a_x_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CORD) |-> !r_x[33])
        else $error("cordic x went negative");
    a_result_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN && out_free) |=> (r_out_valid && r_state == ST_IDLE))
        else $error("result not loaded");
    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_q_ready)
        else $error("queue popped while busy");
endmodule
`default_nettype wire

/* hdl/imu_pitch_yaw_estimator.sv */
// top level of the imu pitch and yaw estimator
// depends on ipye_pkg, ipye_front and ipye_back
//
// channel | handshake                  | payload
// in      | i_in_valid / o_in_ready    | accel y/z, gyro x/y/z raw samples
// out     | o_out_valid / i_out_ready  | pitch angle Q3.16 rad, yaw angle Q16.16 rad
// cfg     | i_cfg_valid / o_cfg_ready  | register index and data
//
// in the back end a request passes through a load step, the 16 cordic iterations
// and five multiply, round, blend and commit steps; one request at a time is worked on
// a two-entry queue takes requests while the back end is busy
// the result register holds a finished result while the next request runs
// synchronous active-low reset; the configuration port is always ready
`timescale 1ns / 1ps
`default_nettype none
module imu_pitch_yaw_estimator import ipye_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic signed [15:0] i_accel_y_raw,
    input  wire logic signed [15:0] i_accel_z_raw,
    input  wire logic signed [15:0] i_gyro_x_raw,
    input  wire logic signed [15:0] i_gyro_y_raw,
    input  wire logic signed [15:0] i_gyro_z_raw,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic signed [18:0]      o_pitch_angle,
    output logic signed [31:0]      o_yaw_angle,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [15:0]        i_cfg_data
);
    t_cfg  cfg;
    t_item q_item;
    logic  q_valid, q_ready;

    ipye_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_accel_y_raw (i_accel_y_raw),
        .i_accel_z_raw (i_accel_z_raw),
        .i_gyro_x_raw  (i_gyro_x_raw),
        .i_gyro_y_raw  (i_gyro_y_raw),
        .i_gyro_z_raw  (i_gyro_z_raw),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_cfg         (cfg),
        .o_q_valid     (q_valid),
        .i_q_ready     (q_ready),
        .o_q_item      (q_item)
    );

    ipye_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_q_valid     (q_valid),
        .o_q_ready     (q_ready),
        .i_q_item      (q_item),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_pitch_angle (o_pitch_angle),
        .o_yaw_angle   (o_yaw_angle)
    );
endmodule
`default_nettype wire
